// ----- rtl/oct_pkg.sv -----
// oct_pkg: shared types and constants of the operator and comment tokenizer
// no dependencies; imported by the lexer, the result queue and the top level
`timescale 1ns / 1ps
`default_nettype none

package oct_pkg;

    localparam int LINE_W = 16;

    typedef logic [LINE_W-1:0] t_line;

    // token codes, dense
    typedef enum logic [5:0] {
        K_INC     = 6'd0,
        K_PLUS    = 6'd1,
        K_DEC     = 6'd2,
        K_MINUS   = 6'd3,
        K_STAR    = 6'd4,
        K_MOD     = 6'd5,
        K_COMMA   = 6'd6,
        K_COLON   = 6'd7,
        K_SEMI    = 6'd8,
        K_LPAREN  = 6'd9,
        K_RPAREN  = 6'd10,
        K_LBRACK  = 6'd11,
        K_RBRACK  = 6'd12,
        K_LBRACE  = 6'd13,
        K_RBRACE  = 6'd14,
        K_GE      = 6'd15,
        K_SHR     = 6'd16,
        K_GT      = 6'd17,
        K_LE      = 6'd18,
        K_SHL     = 6'd19,
        K_LT      = 6'd20,
        K_EQ      = 6'd21,
        K_ASSIGN  = 6'd22,
        K_LAND    = 6'd23,
        K_BAND    = 6'd24,
        K_LOR     = 6'd25,
        K_BOR     = 6'd26,
        K_NE      = 6'd27,
        K_NOT     = 6'd28,
        K_DIV     = 6'd29,
        K_COMMENT = 6'd30,
        K_UNKNOWN = 6'd31,
        K_END     = 6'd32
    } t_tok;

    // lexer mode
    typedef enum logic [1:0] {
        M_NORMAL = 2'd0,
        M_LINE   = 2'd1,
        M_BLOCK  = 2'd2,
        M_STAR   = 2'd3
    } t_mode;

    // first character of a possible two-character operator
    typedef enum logic [3:0] {
        P_NONE  = 4'd0,
        P_PLUS  = 4'd1,
        P_MINUS = 4'd2,
        P_GT    = 4'd3,
        P_LT    = 4'd4,
        P_EQ    = 4'd5,
        P_AMP   = 4'd6,
        P_BAR   = 4'd7,
        P_BANG  = 4'd8,
        P_SLASH = 4'd9
    } t_pend;

    // all results caused by one request: zero, one or two tokens on the same line
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       k0;
        t_tok       k1;
        t_line      line;
    } t_row;

endpackage

`default_nettype wire

// ----- rtl/oct_if.sv -----
// oct_in_if / oct_out_if: valid-ready channels of the tokenizer
// depends on oct_pkg for the line number type
`timescale 1ns / 1ps
`default_nettype none

interface oct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface oct_out_if;
    logic           valid;
    logic           ready;
    logic [5:0]     token_kind;
    oct_pkg::t_line line_number;
    logic           last;

    modport source (output valid, output token_kind, output line_number, output last,
                    input ready);
    modport sink   (input valid, input token_kind, input line_number, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/operator_comment_tokenizer.sv -----
// operator_comment_tokenizer: top level of the operator and comment tokenizer
// depends on oct_pkg, oct_if, oct_lexer and oct_queue
//
// usage
// - i_in carries one source byte per request (in_char) and the end flag
//   (end_of_input); in_char is ignored on a request with the end flag set
// - o_out carries one token per request: token_kind, line_number (line on
//   which the token finished, saturating) and last, set on the final token
//   caused by one input request
// - a request is taken at a clock edge with valid and ready both high
// - a token is registered in the result queue before it appears on o_out
// - throughput: one input byte per cycle while the queue has room; a byte that
//   causes two tokens (a pending operator flushed by a one-character token, or
//   end of input after one) is sent as two, so the output sets the sustained rate
// - the result queue holds the tokens of two input requests; i_in.ready is
//   low only while both rows are occupied, so a stalled receiver stops input
//   after at most two token-producing requests and nothing is dropped
// - reset (synchronous, active low) clears the queue and returns the lexer to
//   normal mode, no pending character, line one; end of input does the same
//   after flushing its tokens
`timescale 1ns / 1ps
`default_nettype none

module operator_comment_tokenizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    oct_in_if.sink    i_in,
    oct_out_if.source o_out
);
    import oct_pkg::*;

    t_row row;       // tokens of the byte on the input port
    logic fire;      // input request accepted
    logic room;      // queue can take a row

    assign i_in.ready = room;
    assign fire       = i_in.valid && i_in.ready;

    // lexer state advances on every accepted byte
    oct_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (i_in.in_char),
        .i_end   (i_in.end_of_input),
        .o_row   (row)
    );

    // bytes without tokens (blanks, pending operators, comment body) skip the queue
    oct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && (row.cnt != 2'd0)),
        .i_row   (row),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/oct_lexer.sv -----
// oct_lexer: lexer state (mode, pending first character, line count) and
// the per-byte decode into zero, one or two tokens; depends on oct_pkg
`timescale 1ns / 1ps
`default_nettype none

module oct_lexer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_end,
    output oct_pkg::t_row      o_row
);
    import oct_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    t_mode r_mode, n_mode;
    t_pend r_pend, n_pend;
    t_line r_line, n_line;

    // pending character decode
    logic  s_has;      // a pending character exists
    t_tok  s_single;   // its one-character token
    logic  m_used;     // lookahead byte joins it
    logic  m_emit;     // the joined pair is a token
    t_tok  m_kind;
    t_mode m_mode;     // mode after a joined slash

    // fresh character decode
    logic  f_emit;
    t_tok  f_kind;
    t_pend f_pend;
    logic  f_lf;

    t_line line_inc;
    logic  used;

    assign line_inc = (r_line == {LINE_W{1'b1}}) ? r_line : r_line + t_line'(1);
    assign used     = s_has && m_used;

    // resolve the pending character against the current byte
    always_comb begin
        s_has    = 1'b1;
        s_single = K_UNKNOWN;
        m_used   = 1'b0;
        m_emit   = 1'b0;
        m_kind   = K_UNKNOWN;
        m_mode   = M_NORMAL;
        unique case (r_pend)
            P_PLUS: begin
                s_single = K_PLUS;
                m_used   = (i_char == CH_PLUS);
                m_emit   = m_used;
                m_kind   = K_INC;
            end
            P_MINUS: begin
                s_single = K_MINUS;
                m_used   = (i_char == CH_MINUS);
                m_emit   = m_used;
                m_kind   = K_DEC;
            end
            P_GT: begin
                s_single = K_GT;
                m_used   = (i_char == CH_EQ) || (i_char == CH_GT);
                m_emit   = m_used;
                m_kind   = (i_char == CH_EQ) ? K_GE : K_SHR;
            end
            P_LT: begin
                s_single = K_LT;
                m_used   = (i_char == CH_EQ) || (i_char == CH_LT);
                m_emit   = m_used;
                m_kind   = (i_char == CH_EQ) ? K_LE : K_SHL;
            end
            P_EQ: begin
                s_single = K_ASSIGN;
                m_used   = (i_char == CH_EQ);
                m_emit   = m_used;
                m_kind   = K_EQ;
            end
            P_AMP: begin
                s_single = K_BAND;
                m_used   = (i_char == CH_AMP);
                m_emit   = m_used;
                m_kind   = K_LAND;
            end
            P_BAR: begin
                s_single = K_BOR;
                m_used   = (i_char == CH_BAR);
                m_emit   = m_used;
                m_kind   = K_LOR;
            end
            P_BANG: begin
                s_single = K_NOT;
                m_used   = (i_char == CH_EQ);
                m_emit   = m_used;
                m_kind   = K_NE;
            end
            P_SLASH: begin
                // slash pair opens a comment and gives no token yet
                s_single = K_DIV;
                m_used   = (i_char == CH_SLASH) || (i_char == CH_STAR);
                m_mode   = (i_char == CH_SLASH) ? M_LINE : M_BLOCK;
            end
            default: begin
                s_has = 1'b0;
            end
        endcase
    end

    // classify the byte on its own
    always_comb begin
        f_emit = 1'b1;
        f_kind = K_UNKNOWN;
        f_pend = P_NONE;
        f_lf   = 1'b0;
        unique case (i_char) inside
            CH_SP, CH_TAB, CH_CR: f_emit = 1'b0;
            CH_LF: begin
                f_emit = 1'b0;
                f_lf   = 1'b1;
            end
            CH_PLUS:  begin f_emit = 1'b0; f_pend = P_PLUS;  end
            CH_MINUS: begin f_emit = 1'b0; f_pend = P_MINUS; end
            CH_GT:    begin f_emit = 1'b0; f_pend = P_GT;    end
            CH_LT:    begin f_emit = 1'b0; f_pend = P_LT;    end
            CH_EQ:    begin f_emit = 1'b0; f_pend = P_EQ;    end
            CH_AMP:   begin f_emit = 1'b0; f_pend = P_AMP;   end
            CH_BAR:   begin f_emit = 1'b0; f_pend = P_BAR;   end
            CH_BANG:  begin f_emit = 1'b0; f_pend = P_BANG;  end
            CH_SLASH: begin f_emit = 1'b0; f_pend = P_SLASH; end
            CH_STAR:  f_kind = K_STAR;
            CH_PCT:   f_kind = K_MOD;
            CH_COMMA: f_kind = K_COMMA;
            CH_COLON: f_kind = K_COLON;
            CH_SEMI:  f_kind = K_SEMI;
            CH_LPAR:  f_kind = K_LPAREN;
            CH_RPAR:  f_kind = K_RPAREN;
            CH_LBRK:  f_kind = K_LBRACK;
            CH_RBRK:  f_kind = K_RBRACK;
            CH_LBRC:  f_kind = K_LBRACE;
            CH_RBRC:  f_kind = K_RBRACE;
            default:  f_kind = K_UNKNOWN;
        endcase
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_pend = r_pend;
        n_line = r_line;
        if (i_end) begin
            n_mode = M_NORMAL;
            n_pend = P_NONE;
            n_line = t_line'(1);
        end else begin
            unique case (r_mode)
                M_LINE: begin
                    if (i_char == CH_LF) begin
                        n_mode = M_NORMAL;
                        n_line = line_inc;
                    end
                end
                M_BLOCK: begin
                    if (i_char == CH_STAR) begin
                        n_mode = M_STAR;
                    end else if (i_char == CH_LF) begin
                        n_line = line_inc;
                    end
                end
                M_STAR: begin
                    if (i_char == CH_SLASH) begin
                        n_mode = M_NORMAL;
                    end else if (i_char != CH_STAR) begin
                        n_mode = M_BLOCK;
                        if (i_char == CH_LF) begin
                            n_line = line_inc;
                        end
                    end
                end
                default: begin
                    n_mode = M_NORMAL;
                    n_pend = P_NONE;
                    if (used) begin
                        n_mode = m_mode;
                    end else begin
                        n_pend = f_pend;
                        if (f_lf) begin
                            n_line = line_inc;
                        end
                    end
                end
            endcase
        end
    end

    // tokens caused by this byte
    always_comb begin
        o_row.cnt  = 2'd0;
        o_row.k0   = K_END;
        o_row.k1   = K_END;
        o_row.line = r_line;
        if (i_end) begin
            if (r_mode == M_NORMAL && s_has) begin
                o_row.k0  = s_single;
                o_row.cnt = 2'd2;
            end else if (r_mode == M_LINE) begin
                o_row.k0  = K_COMMENT;
                o_row.cnt = 2'd2;
            end else begin
                o_row.cnt = 2'd1;
            end
        end else begin
            unique case (r_mode)
                M_LINE: begin
                    if (i_char == CH_LF) begin
                        o_row.k0  = K_COMMENT;
                        o_row.cnt = 2'd1;
                    end
                end
                M_BLOCK: begin
                    o_row.cnt = 2'd0;
                end
                M_STAR: begin
                    if (i_char == CH_SLASH) begin
                        o_row.k0  = K_COMMENT;
                        o_row.cnt = 2'd1;
                    end
                end
                default: begin
                    if (s_has && (!m_used || m_emit)) begin
                        o_row.k0  = m_used ? m_kind : s_single;
                        o_row.cnt = 2'd1;
                    end
                    if (!used && f_emit) begin
                        if (o_row.cnt == 2'd0) begin
                            o_row.k0 = f_kind;
                        end else begin
                            o_row.k1 = f_kind;
                        end
                        o_row.cnt = o_row.cnt + 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_pend <= P_NONE;
            r_line <= t_line'(1);
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_line <= n_line;
        end
    end

    // a pending character only exists in normal mode
    a_pend_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != P_NONE) |-> (r_mode == M_NORMAL))
        else $error("pending character outside normal mode");

    // the line count never falls to zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count reached zero");

endmodule

`default_nettype wire

// ----- rtl/oct_queue.sv -----
// oct_queue: two-row result queue; each row holds the one or two tokens of
// one request and is drained one token per output request; depends on oct_pkg
`timescale 1ns / 1ps
`default_nettype none

module oct_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire oct_pkg::t_row i_row,
    output logic               o_room,
    oct_out_if.source          o_out
);
    import oct_pkg::*;

    t_row       r_row [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       r_sub;
    t_row       head;
    logic       pop_tok;
    logic       pop_row;

    assign head    = r_row[r_rp];
    assign o_room  = (r_count != 2'd2);
    assign pop_tok = o_out.valid && o_out.ready;
    assign pop_row = pop_tok && o_out.last;

    assign o_out.valid       = (r_count != 2'd0);
    assign o_out.token_kind  = r_sub ? head.k1 : head.k0;
    assign o_out.line_number = head.line;
    assign o_out.last        = r_sub || (head.cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_row[r_wp] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_row) begin
                r_rp  <= ~r_rp;
                r_sub <= 1'b0;
            end else if (pop_tok) begin
                r_sub <= 1'b1;
            end
            if (i_push && !pop_row) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && pop_row) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (head.cnt == 2'd1 || head.cnt == 2'd2))
        else $error("empty row in result queue");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_tok && !o_out.last) |=> (o_out.valid && r_sub))
        else $error("second token of a row lost");

    a_no_empty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_row.cnt != 2'd0))
        else $error("row without tokens pushed");

endmodule

`default_nettype wire
